>>> rtl/rvdec_pkg.sv
`timescale 1ns / 1ps

package rvdec_pkg;

    localparam int WORD_W = 32;
    localparam int IMM_W  = 21;
    localparam int CNT_W  = 20;
    localparam int BOFF_W = 13;
    localparam int JOFF_W = 21;

    typedef logic [5:0] t_mnem;
    typedef logic [3:0] t_fmt;
    typedef logic [6:0] t_opcode;

    localparam t_opcode OP_REG    = 7'h33;
    localparam t_opcode OP_IMM    = 7'h13;
    localparam t_opcode OP_LOAD   = 7'h03;
    localparam t_opcode OP_STORE  = 7'h23;
    localparam t_opcode OP_BRANCH = 7'h63;
    localparam t_opcode OP_JAL    = 7'h6F;
    localparam t_opcode OP_JALR   = 7'h67;
    localparam t_opcode OP_LUI    = 7'h37;
    localparam t_opcode OP_AUIPC  = 7'h17;

    localparam t_fmt FC_R      = 4'd0;
    localparam t_fmt FC_IALU   = 4'd1;
    localparam t_fmt FC_LOAD   = 4'd2;
    localparam t_fmt FC_STORE  = 4'd3;
    localparam t_fmt FC_BRANCH = 4'd4;
    localparam t_fmt FC_JAL    = 4'd5;
    localparam t_fmt FC_JALR   = 4'd6;
    localparam t_fmt FC_LUI    = 4'd7;
    localparam t_fmt FC_AUIPC  = 4'd8;

    localparam t_mnem MN_ADD     = 6'd0;
    localparam t_mnem MN_SUB     = 6'd8;
    localparam t_mnem MN_SRA     = 6'd9;
    localparam t_mnem MN_ADDI    = 6'd10;
    localparam t_mnem MN_SLLI    = 6'd11;
    localparam t_mnem MN_SLTI    = 6'd12;
    localparam t_mnem MN_SLTIU   = 6'd13;
    localparam t_mnem MN_XORI    = 6'd14;
    localparam t_mnem MN_SRLI    = 6'd15;
    localparam t_mnem MN_SRAI    = 6'd16;
    localparam t_mnem MN_ORI     = 6'd17;
    localparam t_mnem MN_ANDI    = 6'd18;
    localparam t_mnem MN_LB      = 6'd19;
    localparam t_mnem MN_SB      = 6'd26;
    localparam t_mnem MN_BEQ     = 6'd30;
    localparam t_mnem MN_BNE     = 6'd31;
    localparam t_mnem MN_BLT     = 6'd32;
    localparam t_mnem MN_JAL     = 6'd36;
    localparam t_mnem MN_JALR    = 6'd37;
    localparam t_mnem MN_LUI     = 6'd38;
    localparam t_mnem MN_AUIPC   = 6'd39;
    localparam t_mnem MN_UNKNOWN = 6'd40;

    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [5:0] F6_ARTH = 6'h10;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SLT = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_SR  = 3'd5;
    localparam logic [2:0] F3_OR  = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;

endpackage

>>> rtl/rv64i_instruction_decoder_unit.sv
`timescale 1ns / 1ps

// Channel | Handshake                 | Payload
// --------+---------------------------+-------------------------------------------
// in      | i_in_valid / o_in_ready   | i_instr_word
// out     | o_out_valid / i_out_ready | o_recognized .. o_label_here, one port each
//
// Path from input beat to result: input register, then decode and label
// tracker update into the result register. One beat per cycle unless stalled.
// Synchronous active-low reset clears the valid flags and label trackers.
// Stalls: a stalled output holds the result register; input ready drops
// only when both registers are full and the output is stalled.

module rv64i_instruction_decoder_unit
    import rvdec_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [WORD_W-1:0]       i_instr_word,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_recognized,
    output logic [3:0]              o_format_class,
    output logic [5:0]              o_mnemonic,
    output logic [4:0]              o_rd,
    output logic [4:0]              o_rs1,
    output logic [4:0]              o_rs2,
    output logic signed [IMM_W-1:0] o_imm,
    output logic                    o_label_here
);

    logic              r_s1_valid;
    logic [WORD_W-1:0] r_word;
    logic              r_out_valid;

    logic              r_br_pend, n_br_pend;
    logic [BOFF_W-1:0] r_br_off,  n_br_off;
    logic [CNT_W-1:0]  r_br_cnt,  n_br_cnt;
    logic              r_jp_pend, n_jp_pend;
    logic [JOFF_W-1:0] r_jp_off,  n_jp_off;
    logic [CNT_W-1:0]  r_jp_cnt,  n_jp_cnt;

    logic              r_recog;
    t_fmt              r_fmt;
    t_mnem             r_mnem;
    logic [4:0]        r_rd, r_rs1, r_rs2;
    logic [IMM_W-1:0]  r_imm;
    logic              r_label;

    logic              s2_ready, s1_move;
    t_opcode           op;
    logic [2:0]        f3;
    logic [6:0]        f7;
    logic [5:0]        f6;
    logic [IMM_W-1:0]  iimm, simm, bimm, jimm, uimm;
    t_fmt              n_fmt;
    t_mnem             n_mnem;
    logic [IMM_W-1:0]  n_imm;
    logic              n_recog, br_hit, jp_hit, n_label;

    assign s2_ready   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && s2_ready;
    assign o_in_ready = !r_s1_valid || s2_ready;

    assign op = r_word[6:0];
    assign f3 = r_word[14:12];
    assign f7 = r_word[31:25];
    assign f6 = r_word[31:26];

    assign iimm = {{9{r_word[31]}}, r_word[31:20]};
    assign simm = {{9{r_word[31]}}, r_word[31:25], r_word[11:7]};
    assign bimm = {{8{r_word[31]}}, r_word[31], r_word[7], r_word[30:25],
                   r_word[11:8], 1'b0};
    assign jimm = {r_word[31], r_word[19:12], r_word[20], r_word[30:21], 1'b0};
    assign uimm = {1'b0, r_word[31:12]};

    always_comb begin
        n_fmt  = FC_R;
        n_mnem = MN_UNKNOWN;
        n_imm  = '0;
        unique case (op)
            OP_REG: begin
                n_fmt = FC_R;
                if (f7 == '0) begin
                    n_mnem = MN_ADD + t_mnem'(f3);
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    n_mnem = MN_SUB;
                end else if (f7 == F7_ALT && f3 == F3_SR) begin
                    n_mnem = MN_SRA;
                end
            end
            OP_IMM: begin
                n_fmt = FC_IALU;
                n_imm = iimm;
                unique case (f3)
                    F3_ADD:  n_mnem = MN_ADDI;
                    F3_SLL:  n_mnem = (f6 == '0) ? MN_SLLI : MN_UNKNOWN;
                    F3_SLT:  n_mnem = MN_SLTI;
                    F3_SLTU: n_mnem = MN_SLTIU;
                    F3_XOR:  n_mnem = MN_XORI;
                    F3_SR:   n_mnem = (f6 == '0) ? MN_SRLI :
                                      (f6 == F6_ARTH) ? MN_SRAI : MN_UNKNOWN;
                    F3_OR:   n_mnem = MN_ORI;
                    F3_AND:  n_mnem = MN_ANDI;
                    default: n_mnem = MN_UNKNOWN;
                endcase
            end
            OP_LOAD: begin
                n_fmt = FC_LOAD;
                n_imm = iimm;
                if (f3 != F3_AND) n_mnem = MN_LB + t_mnem'(f3);
            end
            OP_STORE: begin
                n_fmt = FC_STORE;
                n_imm = simm;
                if (!f3[2]) n_mnem = MN_SB + t_mnem'(f3);
            end
            OP_BRANCH: begin
                n_fmt = FC_BRANCH;
                n_imm = bimm;
                if (f3 == F3_ADD) begin
                    n_mnem = MN_BEQ;
                end else if (f3 == F3_SLL) begin
                    n_mnem = MN_BNE;
                end else if (f3[2]) begin
                    n_mnem = MN_BLT + t_mnem'(f3[1:0]);
                end
            end
            OP_JAL: begin
                n_fmt  = FC_JAL;
                n_imm  = jimm;
                n_mnem = MN_JAL;
            end
            OP_JALR: begin
                n_fmt = FC_JALR;
                n_imm = iimm;
                if (f3 == F3_ADD) n_mnem = MN_JALR;
            end
            OP_LUI: begin
                n_fmt  = FC_LUI;
                n_imm  = uimm;
                n_mnem = MN_LUI;
            end
            OP_AUIPC: begin
                n_fmt  = FC_AUIPC;
                n_imm  = uimm;
                n_mnem = MN_AUIPC;
            end
            default: begin
                n_mnem = MN_UNKNOWN;
            end
        endcase
        n_recog = (n_mnem != MN_UNKNOWN);
        if (!n_recog) begin
            n_fmt = FC_R;
            n_imm = '0;
        end
    end

    // label test on the tracker state seen before this instruction
    always_comb begin
        br_hit  = r_br_pend && !r_br_off[BOFF_W-1] &&
                  ({r_br_cnt, 2'b00} == (CNT_W+2)'(r_br_off));
        jp_hit  = r_jp_pend && !r_jp_off[JOFF_W-1] &&
                  ({r_jp_cnt, 2'b00} == (CNT_W+2)'(r_jp_off));
        n_label = br_hit || jp_hit;

        n_br_pend = r_br_pend;
        n_br_off  = r_br_off;
        n_br_cnt  = r_br_cnt;
        n_jp_pend = r_jp_pend;
        n_jp_off  = r_jp_off;
        n_jp_cnt  = r_jp_cnt;
        if (n_label) begin
            n_br_pend = 1'b0;
            n_br_off  = '0;
            n_br_cnt  = '0;
            n_jp_pend = 1'b0;
            n_jp_off  = '0;
            n_jp_cnt  = '0;
        end
        if (n_recog && n_fmt == FC_BRANCH) begin
            n_br_pend = 1'b1;
            n_br_off  = n_imm[BOFF_W-1:0];
            n_br_cnt  = '0;
        end else if (n_recog && n_fmt == FC_JAL) begin
            n_jp_pend = 1'b1;
            n_jp_off  = n_imm[JOFF_W-1:0];
            n_jp_cnt  = '0;
        end
        if (n_br_pend && n_br_cnt != '1) n_br_cnt = n_br_cnt + 1'b1;
        if (n_jp_pend && n_jp_cnt != '1) n_jp_cnt = n_jp_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_br_pend   <= 1'b0;
            r_br_off    <= '0;
            r_br_cnt    <= '0;
            r_jp_pend   <= 1'b0;
            r_jp_off    <= '0;
            r_jp_cnt    <= '0;
        end else begin
            if (o_in_ready) r_s1_valid <= i_in_valid;
            if (s2_ready) r_out_valid <= r_s1_valid;
            if (s1_move) begin
                r_br_pend <= n_br_pend;
                r_br_off  <= n_br_off;
                r_br_cnt  <= n_br_cnt;
                r_jp_pend <= n_jp_pend;
                r_jp_off  <= n_jp_off;
                r_jp_cnt  <= n_jp_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_word <= i_instr_word;
        if (s1_move) begin
            r_recog <= n_recog;
            r_fmt   <= n_fmt;
            r_mnem  <= n_mnem;
            r_rd    <= r_word[11:7];
            r_rs1   <= r_word[19:15];
            r_rs2   <= r_word[24:20];
            r_imm   <= n_imm;
            r_label <= n_label;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_recognized   = r_recog;
    assign o_format_class = r_fmt;
    assign o_mnemonic     = r_mnem;
    assign o_rd           = r_rd;
    assign o_rs1          = r_rs1;
    assign o_rs2          = r_rs2;
    assign o_imm          = $signed(r_imm);
    assign o_label_here   = r_label;

endmodule

>>> rtl/rvdec_checker.sv
`timescale 1ns / 1ps

module rvdec_checker
    import rvdec_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic [WORD_W-1:0]       i_instr_word,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic                    o_recognized,
    input logic [3:0]              o_format_class,
    input logic [5:0]              o_mnemonic,
    input logic [4:0]              o_rd,
    input logic [4:0]              o_rs1,
    input logic [4:0]              o_rs2,
    input logic signed [IMM_W-1:0] o_imm,
    input logic                    o_label_here
);

    a_unknown_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_recognized) |->
        (o_format_class == FC_R && o_mnemonic == MN_UNKNOWN && o_imm == '0))
        else $error("unrecognized beat carries class, code or immediate");

    a_known_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_recognized) |->
        (o_mnemonic < MN_UNKNOWN && o_format_class <= FC_AUIPC))
        else $error("recognized beat has unknown code or bad class");

    a_upper_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_recognized &&
         (o_format_class == FC_LUI || o_format_class == FC_AUIPC)) |->
        (o_imm >= 0))
        else $error("upper immediate must be non-negative");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_mnemonic) && $stable(o_imm) &&
         $stable(o_label_here)))
        else $error("stalled output beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind rv64i_instruction_decoder_unit rvdec_checker u_rvdec_checker (.*);
